[rtl/mlbs_pkg.sv]
package mlbs_pkg;

  localparam int LIGHT_COUNT  = 5;

  localparam int COORD_W      = 9;
  localparam int HEIGHT_W     = 8;
  localparam int VALUE_W      = 8;
  localparam int AXIS_W       = 8;
  localparam int TABLE_ADDR_W = 2 * AXIS_W;
  localparam int GRAD_W       = HEIGHT_W + 1;
  // grad - pos + light + bias spans -638..894
  localparam int AXIS_SUM_W   = COORD_W + 2;
  localparam int SUM_W        = VALUE_W + $clog2(LIGHT_COUNT);
  localparam int CFG_INDEX_W  = 3;

  localparam int AXIS_BIAS    = 128;
  localparam int VALUE_MAX    = 255;

  localparam int IN_FIELDS_W  = TABLE_ADDR_W + VALUE_W + 4 * HEIGHT_W + 2 * COORD_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = VALUE_W + 2 * COORD_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_SHADE = 1'b1
  } func_t;

  typedef struct packed {
    logic               enable;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } light_t;

  localparam int LIGHT_REG_W = $bits(light_t);

  // first field in the lowest bits
  typedef struct packed {
    logic [IN_DATA_W-IN_FIELDS_W-1:0] pad;
    logic [COORD_W-1:0]               pixel_y;
    logic [COORD_W-1:0]               pixel_x;
    logic [HEIGHT_W-1:0]              height_below;
    logic [HEIGHT_W-1:0]              height_above;
    logic [HEIGHT_W-1:0]              height_right;
    logic [HEIGHT_W-1:0]              height_left;
    logic [VALUE_W-1:0]               table_value;
    logic [TABLE_ADDR_W-1:0]          table_address;
  } in_data_t;

  typedef struct packed {
    logic [OUT_DATA_W-OUT_FIELDS_W-1:0] pad;
    logic [COORD_W-1:0]                 out_y;
    logic [COORD_W-1:0]                 out_x;
    logic [VALUE_W-1:0]                 intensity;
  } out_data_t;

  // One table axis: grad - (pos - light) + 128, anything outside 0..255 gives 255.
  function automatic logic [AXIS_W-1:0] axis_index(
    logic signed [GRAD_W-1:0] grad,
    logic [COORD_W-1:0]       pos,
    logic [COORD_W-1:0]       light
  );
    logic signed [AXIS_SUM_W-1:0] g_ext;
    logic signed [AXIS_SUM_W-1:0] p_ext;
    logic signed [AXIS_SUM_W-1:0] l_ext;
    logic signed [AXIS_SUM_W-1:0] v;
    g_ext = {{(AXIS_SUM_W-GRAD_W){grad[GRAD_W-1]}}, grad};
    p_ext = {{(AXIS_SUM_W-COORD_W){1'b0}}, pos};
    l_ext = {{(AXIS_SUM_W-COORD_W){1'b0}}, light};
    v = g_ext - p_ext + l_ext + AXIS_SUM_W'(AXIS_BIAS);
    if (v[AXIS_SUM_W-1:AXIS_W] != '0) begin
      return '1;
    end
    return v[AXIS_W-1:0];
  endfunction

endpackage

[rtl/mlbs_ram.sv]
module mlbs_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/multi_light_bump_shader.sv]
// Channel  Direction  Ports                                 Carries
// s        in         s_tvalid s_tready s_tdata s_tuser     table write or pixel request
// m        out        m_tvalid m_tready m_tdata             shaded pixel
// cfg      in         cfg_valid cfg_ready cfg_index cfg_data light registers 0..4
//
// One request per clock, sustained while m is not stalled. A shade request reaches
// m_tdata through four register stages, counting the accepting edge
// (gradients, table axes, table read, sum and saturate).
// The rate is set by one read port per light: each light has its own copy of the
// 64K-entry table, all copies written together by table-write requests.
// rst is synchronous, active high; it clears the stage valids and the light
// registers. The table has no reset and must be written before it is read.
// Each stage advances when the one after it is empty or moving, so a stall
// at m only backs up as far as the first free stage; nothing is dropped.
module multi_light_bump_shader (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // table_address, table_value, height_left, height_right, height_above,
  // height_below, pixel_x, pixel_y, zero pad
  input  logic [mlbs_pkg::IN_DATA_W-1:0]       s_tdata,
  // func
  input  logic                                 s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // intensity, out_x, out_y, zero pad
  output logic [mlbs_pkg::OUT_DATA_W-1:0]      m_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mlbs_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mlbs_pkg::LIGHT_REG_W-1:0]     cfg_data
);

  // ---- light registers ----
  mlbs_pkg::light_t light_reg [mlbs_pkg::LIGHT_COUNT];

  assign cfg_ready = 1'b1;

  // index beyond the light count matches no register and is dropped
  for (genvar i = 0; i < mlbs_pkg::LIGHT_COUNT; i++) begin : g_light_reg
    always_ff @(posedge clk) begin
      if (rst) begin
        light_reg[i] <= '0;
      end else if (cfg_valid && cfg_ready &&
                   cfg_index == mlbs_pkg::CFG_INDEX_W'(i)) begin
        light_reg[i] <= mlbs_pkg::light_t'(cfg_data);
      end
    end
  end

  // ---- stage handshakes ----
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic s1_ready, s2_ready, s3_ready, s4_ready;

  assign s4_ready = !s4_valid || m_tready;
  assign s3_ready = !s3_valid || s4_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign s_tready = s1_ready;

  mlbs_pkg::in_data_t in_data;
  assign in_data = mlbs_pkg::in_data_t'(s_tdata);

  // ---- stage 1: gradients ----
  mlbs_pkg::func_t                               s1_func;
  logic [mlbs_pkg::TABLE_ADDR_W-1:0]             s1_addr;
  logic [mlbs_pkg::VALUE_W-1:0]                  s1_value;
  logic signed [mlbs_pkg::GRAD_W-1:0]            s1_gx;
  logic signed [mlbs_pkg::GRAD_W-1:0]            s1_gy;
  logic [mlbs_pkg::COORD_W-1:0]                  s1_x;
  logic [mlbs_pkg::COORD_W-1:0]                  s1_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s1_ready) begin
      s1_func  <= mlbs_pkg::func_t'(s_tuser);
      s1_addr  <= in_data.table_address;
      s1_value <= in_data.table_value;
      s1_gx    <= {1'b0, in_data.height_right} - {1'b0, in_data.height_left};
      s1_gy    <= {1'b0, in_data.height_below} - {1'b0, in_data.height_above};
      s1_x     <= in_data.pixel_x;
      s1_y     <= in_data.pixel_y;
    end
  end

  // ---- stage 2: per-light table address ----
  mlbs_pkg::func_t                               s2_func;
  logic [mlbs_pkg::TABLE_ADDR_W-1:0]             s2_addr;
  logic [mlbs_pkg::VALUE_W-1:0]                  s2_value;
  logic [mlbs_pkg::TABLE_ADDR_W-1:0]             s2_rd_addr [mlbs_pkg::LIGHT_COUNT];
  logic [mlbs_pkg::COORD_W-1:0]                  s2_x;
  logic [mlbs_pkg::COORD_W-1:0]                  s2_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      s2_func  <= s1_func;
      s2_addr  <= s1_addr;
      s2_value <= s1_value;
      s2_x     <= s1_x;
      s2_y     <= s1_y;
    end
  end

  // row in the upper byte, column in the lower
  for (genvar i = 0; i < mlbs_pkg::LIGHT_COUNT; i++) begin : g_axis
    always_ff @(posedge clk) begin
      if (s1_valid && s2_ready) begin
        s2_rd_addr[i] <= {mlbs_pkg::axis_index(s1_gy, s1_y, light_reg[i].y),
                          mlbs_pkg::axis_index(s1_gx, s1_x, light_reg[i].x)};
      end
    end
  end

  // ---- stage 3: table read, or table write for write requests ----
  logic                                          ram_wr;
  logic                                          ram_rd;
  logic [mlbs_pkg::VALUE_W-1:0]                  s3_rd_data [mlbs_pkg::LIGHT_COUNT];
  logic [mlbs_pkg::COORD_W-1:0]                  s3_x;
  logic [mlbs_pkg::COORD_W-1:0]                  s3_y;

  // writes retire here, in stream order with the reads
  assign ram_wr = s2_valid && s3_ready && s2_func == mlbs_pkg::FUNC_WRITE;
  assign ram_rd = s2_valid && s3_ready && s2_func == mlbs_pkg::FUNC_SHADE;

  for (genvar i = 0; i < mlbs_pkg::LIGHT_COUNT; i++) begin : g_table
    mlbs_ram #(
      .ADDR_W (mlbs_pkg::TABLE_ADDR_W),
      .DATA_W (mlbs_pkg::VALUE_W)
    ) u_table (
      .clk     (clk),
      .wr_en   (ram_wr),
      .wr_addr (s2_addr),
      .wr_data (s2_value),
      .rd_en   (ram_rd),
      .rd_addr (s2_rd_addr[i]),
      .rd_data (s3_rd_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= ram_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_rd) begin
      s3_x <= s2_x;
      s3_y <= s2_y;
    end
  end

  // ---- stage 4: sum over enabled lights, saturate ----
  logic [mlbs_pkg::SUM_W-1:0]                    sum;
  logic [mlbs_pkg::VALUE_W-1:0]                  sat_sum;
  logic [mlbs_pkg::VALUE_W-1:0]                  s4_intensity;
  logic [mlbs_pkg::COORD_W-1:0]                  s4_x;
  logic [mlbs_pkg::COORD_W-1:0]                  s4_y;
  mlbs_pkg::out_data_t                           out_data;

  always_comb begin
    sum = '0;
    for (int i = 0; i < mlbs_pkg::LIGHT_COUNT; i++) begin
      if (light_reg[i].enable) begin
        sum = sum + mlbs_pkg::SUM_W'(s3_rd_data[i]);
      end
    end
  end

  assign sat_sum = (sum > mlbs_pkg::SUM_W'(mlbs_pkg::VALUE_MAX)) ?
                   mlbs_pkg::VALUE_W'(mlbs_pkg::VALUE_MAX) : sum[mlbs_pkg::VALUE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_ready) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid && s4_ready) begin
      s4_intensity <= sat_sum;
      s4_x         <= s3_x;
      s4_y         <= s3_y;
    end
  end

  always_comb begin
    out_data           = '0;
    out_data.intensity = s4_intensity;
    out_data.out_x     = s4_x;
    out_data.out_y     = s4_y;
  end

  assign m_tvalid = s4_valid;
  assign m_tdata  = out_data;

`ifndef NO_ASSERTIONS
  // a table write never occupies the read stage
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    ram_wr |=> !s3_valid)
    else $error("table write request entered the read stage");

  // read data of a held stage-3 item must not be overwritten; a disabled
  // light may read an unloaded entry, so only light 0 is watched, and only while enabled
  a_read_held: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && !s4_ready && light_reg[0].enable) |=> $stable(s3_rd_data[0]))
    else $error("table read data changed under a stalled item");

  // one table port action per cycle
  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ram_wr, ram_rd}))
    else $error("table read and write issued together");

  // a read is only issued from a valid stage 2
  a_read_valid: assert property (@(posedge clk) disable iff (rst)
    ram_rd |-> s2_valid && s3_ready)
    else $error("table read without a valid shade request");
`endif

endmodule

[tb/multi_light_bump_shader_test.sv]
`timescale 1ns / 1ps

module multi_light_bump_shader_test;
  import mlbs_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 9;
  localparam int ITEM_TARGET  = 1600;
  localparam int PHASE_ITEMS  = 150;
  localparam int MAX_GAP      = 19;
  // pipeline is four deep; leave margin before touching the light registers
  localparam int DRAIN_CYCLES = 10;
  // ~1600 requests, each with a worst-case idle gap and a worst-case stall, plus phases
  localparam int CYCLE_LIMIT  = 400_000;
  localparam int REPORT_MAX   = 10;
  localparam int AXIS_MAX     = (1 << AXIS_W) - 1;
  localparam int LUT_DEPTH    = 1 << TABLE_ADDR_W;

  // Mirror of the shader: light registers, light table, and the
  // pixels still owed by the block, oldest first.
  class shade_predictor;
    light_t             lights [LIGHT_COUNT];
    logic [VALUE_W-1:0] lut_mem [LUT_DEPTH];
    bit                 written [LUT_DEPTH];
    out_data_t          expected_pixels [$];
    int                 errors;

    function new();
      foreach (lights[i]) lights[i] = '0;
      errors = 0;
    endfunction

    // grad - (pos - light) + bias, clamped to the last entry when off the table
    function logic [AXIS_W-1:0] axis(int grad, int pos, int light);
      int v;
      v = grad - pos + light + AXIS_BIAS;
      if (v < 0 || v > AXIS_MAX) return '1;
      return AXIS_W'(v);
    endfunction

    // table entry that light l reads for the pixel in d: column + row * 256
    function logic [TABLE_ADDR_W-1:0] lut_addr(light_t l, in_data_t d);
      int gx, gy;
      gx = int'(d.height_right) - int'(d.height_left);
      gy = int'(d.height_below) - int'(d.height_above);
      return {axis(gy, int'(d.pixel_y), int'(l.y)), axis(gx, int'(d.pixel_x), int'(l.x))};
    endfunction

    function void note_light(logic [CFG_INDEX_W-1:0] idx, light_t val);
      // indexes past the last light are dropped by the block
      if (int'(idx) < LIGHT_COUNT) lights[idx] = val;
    endfunction

    function void note_request(func_t f, in_data_t d);
      int        total;
      out_data_t e;
      if (f == FUNC_WRITE) begin
        lut_mem[d.table_address] = d.table_value;
        written[d.table_address] = 1'b1;
        return;
      end
      total = 0;
      foreach (lights[i]) begin
        if (lights[i].enable) total += int'(lut_mem[lut_addr(lights[i], d)]);
      end
      if (total > VALUE_MAX) total = VALUE_MAX;
      e = '0;
      e.intensity = VALUE_W'(total);
      e.out_x     = d.pixel_x;
      e.out_y     = d.pixel_y;
      expected_pixels.push_back(e);
    endfunction

    function void check_pixel(out_data_t got);
      out_data_t e;
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected pixel: intensity %0d x %0d y %0d",
                   got.intensity, got.out_x, got.out_y);
        return;
      end
      e = expected_pixels.pop_front();
      if (got.intensity !== e.intensity || got.out_x !== e.out_x || got.out_y !== e.out_y) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("pixel mismatch: expected intensity %0d x %0d y %0d, got %0d x %0d y %0d",
                   e.intensity, e.out_x, e.out_y, got.intensity, got.out_x, got.out_y);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata;
  logic                   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [LIGHT_REG_W-1:0] cfg_data;

  shade_predictor sb;
  int             items_sent;
  int             cycle_count;
  bit             quiet_in;   // sender stretch with no idle gaps

  multi_light_bump_shader u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // Watchdog: a hung handshake or a lost pixel ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels outstanding",
               cycle_count, sb.expected_pixels.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Every pixel accepted at m is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_pixel(out_data_t'(m_tdata));
  end

  // Result side back-pressure: a fresh stall before each pixel, with
  // occasional stretches of always-ready.
  initial begin : pixel_sink
    int stall;
    int taken;
    bit quiet_out;
    taken     = 0;
    quiet_out = 1'b0;
    m_tready <= 1'b0;
    @(negedge clk);
    forever begin
      if (taken % 40 == 0) quiet_out = ($urandom_range(0, 2) == 0);
      stall = quiet_out ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
      @(negedge clk);
    end
  end

  // One request on s. Called at a falling edge, returns at a falling edge.
  // tvalid only drops when a gap is drawn, so back-to-back requests keep it high.
  task automatic push_request(func_t f, in_data_t d);
    int gap;
    if (items_sent % 50 == 0) quiet_in = ($urandom_range(0, 2) == 0);
    gap = quiet_in ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    sb.note_request(f, d);
    items_sent++;
    @(negedge clk);
  endtask

  // All fields random, including the ones the chosen func ignores.
  function automatic in_data_t rand_fields();
    in_data_t d;
    d               = '0;
    d.table_address = TABLE_ADDR_W'($urandom);
    d.table_value   = VALUE_W'($urandom);
    d.height_left   = HEIGHT_W'($urandom);
    d.height_right  = HEIGHT_W'($urandom);
    d.height_above  = HEIGHT_W'($urandom);
    d.height_below  = HEIGHT_W'($urandom);
    d.pixel_x       = COORD_W'($urandom);
    d.pixel_y       = COORD_W'($urandom);
    return d;
  endfunction

  // Pixel request. Mostly near some light, often with a gentle slope, so the
  // axes land inside the table; the rest fall off it.
  function automatic in_data_t rand_pixel();
    in_data_t d;
    light_t   a;
    int       base;
    d = rand_fields();
    a = sb.lights[$urandom_range(0, LIGHT_COUNT - 1)];
    if ($urandom_range(0, 3) != 0) begin
      d.pixel_x = a.x + COORD_W'($urandom_range(0, 48)) - COORD_W'(24);
      d.pixel_y = a.y + COORD_W'($urandom_range(0, 48)) - COORD_W'(24);
    end
    if ($urandom_range(0, 1) == 1) begin
      base           = $urandom_range(20, 235);
      d.height_left  = HEIGHT_W'(base + $urandom_range(0, 40) - 20);
      d.height_right = HEIGHT_W'(base + $urandom_range(0, 40) - 20);
      d.height_above = HEIGHT_W'(base + $urandom_range(0, 40) - 20);
      d.height_below = HEIGHT_W'(base + $urandom_range(0, 40) - 20);
    end
    return d;
  endfunction

  // Shade one pixel. Any entry it will read that was never loaded gets a
  // table write first; fill >= 0 forces every read entry to that value.
  task automatic shade_pixel(in_data_t d, int fill);
    logic [TABLE_ADDR_W-1:0] a;
    in_data_t                w;
    for (int i = 0; i < LIGHT_COUNT; i++) begin
      if (sb.lights[i].enable) begin
        a = sb.lut_addr(sb.lights[i], d);
        if (fill >= 0 || !sb.written[a]) begin
          w               = rand_fields();
          w.table_address = a;
          w.table_value   = (fill >= 0) ? VALUE_W'(fill) : VALUE_W'($urandom);
          push_request(FUNC_WRITE, w);
        end
      end
    end
    push_request(FUNC_SHADE, d);
  endtask

  task automatic load_entry(logic [TABLE_ADDR_W-1:0] a, logic [VALUE_W-1:0] v);
    in_data_t w;
    w               = rand_fields();
    w.table_address = a;
    w.table_value   = v;
    push_request(FUNC_WRITE, w);
  endtask

  // Light registers are only touched with the pipeline empty.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_light_reg(logic [CFG_INDEX_W-1:0] idx, light_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.note_light(idx, val);
    @(negedge clk);
  endtask

  // Load all lights; optionally also hit the unused indexes, which must be ignored.
  task automatic configure(light_t cfg [LIGHT_COUNT], bit unused_too);
    for (int i = 0; i < LIGHT_COUNT; i++) write_light_reg(CFG_INDEX_W'(i), cfg[i]);
    if (unused_too) begin
      for (int i = LIGHT_COUNT; i < (1 << CFG_INDEX_W); i++)
        write_light_reg(CFG_INDEX_W'(i), light_t'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic in_data_t pixel_at(int hl, int hr, int ha, int hb, int px, int py);
    in_data_t d;
    d              = rand_fields();
    d.height_left  = HEIGHT_W'(hl);
    d.height_right = HEIGHT_W'(hr);
    d.height_above = HEIGHT_W'(ha);
    d.height_below = HEIGHT_W'(hb);
    d.pixel_x      = COORD_W'(px);
    d.pixel_y      = COORD_W'(py);
    return d;
  endfunction

  initial begin : stimulus
    light_t cfg [LIGHT_COUNT];
    int     phase;
    int     solo;
    sb          = new();
    items_sent  = 0;
    cycle_count = 0;
    quiet_in    = 1'b0;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = FUNC_WRITE;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- directed ---
    // Lights still off after reset: table reads are ignored, intensity 0.
    load_entry('0, VALUE_W'(VALUE_MAX));
    load_entry('1, '0);
    push_request(FUNC_SHADE, pixel_at(0, 0, 0, 0, 0, 0));
    push_request(FUNC_SHADE, pixel_at(255, 255, 255, 255, 511, 511));
    drain();

    // Corner and interior lights, one disabled with all coordinate bits set.
    cfg[0] = '{enable: 1'b1, y: '0, x: '0};
    cfg[1] = '{enable: 1'b1, y: '1, x: '1};
    cfg[2] = '{enable: 1'b0, y: '1, x: '1};
    cfg[3] = '{enable: 1'b1, y: COORD_W'(256), x: COORD_W'(256)};
    cfg[4] = '{enable: 1'b1, y: COORD_W'(383), x: COORD_W'(128)};
    configure(cfg, 1'b1);

    // steepest gradients both ways: most axes fall off the table
    shade_pixel(pixel_at(255, 0, 255, 0, 0, 0), -1);
    shade_pixel(pixel_at(0, 255, 0, 255, 511, 511), -1);
    // flat pixel right on a light: that light reads the table center
    shade_pixel(pixel_at(100, 100, 100, 100, 128, 383), -1);
    // every lookup full scale: the sum saturates
    shade_pixel(pixel_at(40, 60, 200, 180, 128, 383), VALUE_MAX);
    // small values: sum stays below saturation
    shade_pixel(pixel_at(10, 20, 30, 40, 256, 256), 1);
    drain();

    // --- random phases ---
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      solo = $urandom_range(0, LIGHT_COUNT - 1);
      foreach (cfg[i]) begin
        cfg[i].x      = pick_coord();
        cfg[i].y      = pick_coord();
        cfg[i].enable = ($urandom_range(0, 3) != 0);
        case (phase)
          0:       cfg[i].enable = 1'b0;       // all off, coordinates still random
          1:       cfg[i].enable = (i == solo); // single light, never saturates
          2:       cfg[i].enable = 1'b1;
          default: ;
        endcase
      end
      configure(cfg, $urandom_range(0, 3) == 0);

      repeat (PHASE_ITEMS) begin
        if (items_sent >= ITEM_TARGET) break;
        // stray table writes anywhere, otherwise a shaded pixel
        if ($urandom_range(0, 9) < 2) push_request(FUNC_WRITE, rand_fields());
        else shade_pixel(rand_pixel(), -1);
      end
      drain();
      phase++;
    end

    if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
